FILE: rtl/core/srta_pkg.sv
package srta_pkg;

  localparam int MAX_RADIX     = 16;
  localparam int MAX_DIGITS    = 32;
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int RADIX_W       = 5;
  localparam int SYM_COUNT     = 16;
  localparam int SYM_IDX_W     = 4;
  localparam int DIGIT_W       = $clog2(MAX_RADIX);
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int SLOT_W        = $clog2(MAX_DIGITS);
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CHAR_W-1:0] SYM_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic [RADIX_W-1:0]    RADIX_RST        = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000000000003938;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RADIX        = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_reg_t;

  typedef logic [SYM_COUNT-1:0][CHAR_W-1:0] sym_table_t;

  typedef struct packed {
    logic busy;
    logic ok;
  } cfg_status_t;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } work_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } back_state_t;

endpackage

FILE: rtl/core/srta_cfg.sv
module srta_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [srta_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [srta_pkg::RADIX_W-1:0]       radix,
  output srta_pkg::sym_table_t               symbols,
  output srta_pkg::cfg_status_t              status
);
  import srta_pkg::*;

  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] sym_lo_r;
  logic [CFG_DATA_W-1:0] sym_hi_r;
  logic [DIGIT_W-1:0]    scan_r;
  logic                  scan_busy_r;
  logic                  bad_r;
  logic                  ok_r;
  logic                  cfg_we;
  logic                  scan_last;
  logic                  range_ok;
  logic                  cur_used;
  logic [CHAR_W-1:0]     cur_sym;
  logic                  bad_now;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RST;
      sym_lo_r <= SYMBOLS_LOW_RST;
      sym_hi_r <= SYMBOLS_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:        radix_r  <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  sym_lo_r <= cfg_data;
        CFG_SYMBOLS_HIGH: sym_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign radix   = radix_r;
  assign symbols = sym_table_t'({sym_hi_r, sym_lo_r});

  // Scan one symbol per cycle against the reserved codes and the later symbols.
  assign cur_sym   = symbols[SYM_IDX_W'(scan_r)];
  assign cur_used  = RADIX_W'(scan_r) < radix_r;
  assign scan_last = scan_r == DIGIT_W'(MAX_RADIX - 1);
  assign range_ok  = (radix_r >= RADIX_W'(2)) && (radix_r <= RADIX_W'(MAX_RADIX));

  always_comb begin
    bad_now = cur_used &&
              (cur_sym == SYM_NUL || cur_sym == SYM_PLUS || cur_sym == SYM_MINUS);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if (cur_used && (DIGIT_W'(j) > scan_r) && (RADIX_W'(j) < radix_r) &&
          (symbols[j] == cur_sym)) begin
        bad_now = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_busy_r <= 1'b1;
      scan_r      <= '0;
      bad_r       <= 1'b0;
      ok_r        <= 1'b0;
    end else if (cfg_we) begin
      scan_busy_r <= 1'b1;
      scan_r      <= '0;
      bad_r       <= 1'b0;
      ok_r        <= 1'b0;
    end else if (scan_busy_r) begin
      bad_r <= bad_r | bad_now;
      if (scan_last) begin
        scan_busy_r <= 1'b0;
        ok_r        <= range_ok & ~(bad_r | bad_now);
      end else begin
        scan_r <= scan_r + DIGIT_W'(1);
      end
    end
  end

  assign status = '{busy: scan_busy_r, ok: ok_r};

endmodule

FILE: rtl/core/srta_front.sv
module srta_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [srta_pkg::VALUE_W-1:0] in_value,
  input  srta_pkg::cfg_status_t            status,
  output logic                             push_valid,
  input  logic                             push_ready,
  output srta_pkg::work_item_t             push_item
);
  import srta_pkg::*;

  logic               held_r;
  logic [VALUE_W-1:0] value_r;
  logic               neg;
  logic               leave;

  assign neg        = value_r[VALUE_W-1];
  // Drop the item when the configuration is bad; otherwise hand it on.
  assign leave      = held_r && !status.busy && (!status.ok || push_ready);
  assign push_valid = held_r && !status.busy && status.ok;
  assign in_ready   = !held_r || leave;

  assign push_item.neg = neg;
  assign push_item.mag = neg ? ('0 - value_r) : value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_r <= 1'b1;
    end else if (leave) begin
      held_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_r <= VALUE_W'(in_value);
    end
  end

endmodule

FILE: rtl/core/srta_queue.sv
module srta_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  srta_pkg::work_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output srta_pkg::work_item_t pop_item
);
  import srta_pkg::*;

  work_item_t        slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

FILE: rtl/core/srta_back.sv
module srta_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  srta_pkg::work_item_t           pop_item,
  input  logic [srta_pkg::RADIX_W-1:0]   radix,
  input  srta_pkg::sym_table_t           symbols,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [srta_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_last
);
  import srta_pkg::*;

  back_state_t        state_r;
  back_state_t        state_nxt;
  logic               neg_r;
  logic [VALUE_W-1:0] work_r;
  logic [VALUE_W-1:0] work_nxt;
  logic [DIGIT_W-1:0] rem_r;
  logic [DIGIT_W-1:0] rem_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [CHAR_W-1:0]  out_char_nxt;
  logic               out_last_r;
  logic               out_last_nxt;

  logic               step_last;
  logic               quot_zero;
  logic               slot_free;
  logic               take;
  logic               digit_done;
  logic               digit_room;
  logic               load_sign;
  logic               load_digit;
  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  read_slot;

  // Long division by the radix, BITS_PER_STEP dividend bits per cycle.
  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] r;
    logic [VALUE_W-1:0] w;
    r     = rem_r;
    w     = work_r;
    trial = '0;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      trial = {r, w[VALUE_W-1]};
      w     = {w[VALUE_W-2:0], 1'b0};
      if (RADIX_W'(trial) >= radix) begin
        r    = DIGIT_W'(RADIX_W'(trial) - radix);
        w[0] = 1'b1;
      end else begin
        r = trial[DIGIT_W-1:0];
      end
    end
    rem_nxt  = r;
    work_nxt = w;
  end

  assign step_last  = step_r == STEP_W'(DIV_STEPS - 1);
  assign quot_zero  = work_nxt == '0;
  assign slot_free  = !out_valid_r || out_ready;
  assign digit_room = cnt_r < CNT_W'(MAX_DIGITS);
  assign write_slot = cnt_r[SLOT_W-1:0];
  assign read_slot  = SLOT_W'(cnt_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid) state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (step_last && quot_zero) state_nxt = neg_r ? BK_SIGN : BK_EMIT;
      end
      BK_SIGN: begin
        if (slot_free) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free && cnt_r == CNT_W'(1)) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready    = state_r == BK_IDLE;
    take         = pop_ready && pop_valid;
    digit_done   = (state_r == BK_DIV) && step_last;
    load_sign    = (state_r == BK_SIGN) && slot_free;
    load_digit   = (state_r == BK_EMIT) && slot_free;
    out_char_nxt = load_sign ? SYM_MINUS : symbols[SYM_IDX_W'(digits_r[read_slot])];
    out_last_nxt = load_digit && (cnt_r == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        cnt_r <= '0;
      end else if (digit_done && digit_room) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (load_digit) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (take) begin
        step_r <= '0;
      end else if (state_r == BK_DIV) begin
        step_r <= step_last ? '0 : step_r + STEP_W'(1);
      end
      if (load_sign || load_digit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      neg_r  <= pop_item.neg;
      work_r <= pop_item.mag;
      rem_r  <= '0;
    end else if (state_r == BK_DIV) begin
      work_r <= work_nxt;
      rem_r  <= step_last ? '0 : rem_nxt;
    end
    if (digit_done && digit_room) begin
      digits_r[write_slot] <= rem_nxt;
    end
    if (load_sign || load_digit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (cnt_r != '0))
    else $error("digit emit with empty digit stack");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count above limit");

  a_take_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r == BK_DIV) && (cnt_r == '0) && (step_r == '0))
    else $error("new item did not start a clean division");

endmodule

FILE: rtl/core/signed_radix_to_ascii.sv
// Converts a signed 32-bit integer to text in a configured radix (2 to MAX_RADIX)
// and sends it one byte per transfer: a '-' for negative values, then the digit
// symbols most significant first, with out_last set on the final byte. Digit d
// is sent as byte d of the symbol registers. A configuration with a radix out of
// range, a used symbol equal to NUL, '+' or '-', or two equal used symbols makes
// every item vanish without output. After reset and after each configuration
// write the symbol check steps through all MAX_RADIX table entries; items wait in
// the input stage until it is done. An item with D digits (1 to 32) passes the
// input stage and the queue, then the divider, which takes 8 dividend bits per
// cycle and yields one digit per division of the whole value, then D bytes (D+1
// if negative) leave at one per cycle when the sink is ready. The input stage and
// a two-entry queue let the next item be accepted and checked while the divider
// and output stage work on the current one.
module signed_radix_to_ascii (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [srta_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srta_pkg::CHAR_W-1:0]       out_char,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srta_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [srta_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import srta_pkg::*;

  // Configuration side: radix, symbol table and the result of the symbol check.
  logic [RADIX_W-1:0] radix;
  sym_table_t         symbols;
  cfg_status_t        status;

  // Front to queue, queue to back.
  logic       push_valid;
  logic       push_ready;
  work_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  work_item_t pop_item;

  // Hold the registers and sweep the used symbols after every write.
  srta_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .radix     (radix),
    .symbols   (symbols),
    .status    (status)
  );

  // Take the value, split off the sign and form the magnitude; drop the item
  // when the configuration is bad.
  srta_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .status     (status),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Buffer classified items so the front keeps accepting while the back works.
  srta_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Divide repeatedly, stack the digits, then send sign and digits out in order.
  srta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .radix     (radix),
    .symbols   (symbols),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srta_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int IDLE_MAX      = 12;    // longest gap or stall drawn per transfer
  localparam int SETTLE_CYCLES = 300;   // covers a full base-2 conversion plus the queue
  localparam int RANDOM_ITEMS  = 220;   // numbers sent over the whole run
  localparam int TIMEOUT_NS    = 10_000_000;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 2'd3;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_byte_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [VALUE_W-1:0]     in_value  = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Local copy of the register file, updated on each cfg transfer.
  logic [RADIX_W-1:0]      cur_radix = RADIX_RST;
  logic [2*CFG_DATA_W-1:0] cur_table = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};

  text_byte_t pending_text[$];   // bytes still owed by the block, oldest first

  int gap_max       = IDLE_MAX;
  int stall_max     = IDLE_MAX;
  int error_count   = 0;
  int numbers_sent  = 0;
  int valid_numbers = 0;
  int bytes_seen    = 0;
  int bytes_counted = 0;         // sink side's view of bytes_seen
  int sink_hold     = 0;
  int settings_used = 0;

  signed_radix_to_ascii i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Text predictor
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] symbol_for(input int digit);
    return cur_table[8*digit +: 8];
  endfunction

  // Settings are usable only with a radix in 2..MAX_RADIX and distinct,
  // printable-enough symbols for every digit in use; bytes above are don't-care.
  function automatic bit settings_ok();
    int r;
    r = cur_radix;
    if (r < 2 || r > MAX_RADIX) return 1'b0;
    for (int i = 0; i < r; i++) begin
      if (symbol_for(i) == SYM_NUL || symbol_for(i) == SYM_PLUS ||
          symbol_for(i) == SYM_MINUS) return 1'b0;
      for (int j = i + 1; j < r; j++)
        if (symbol_for(i) == symbol_for(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the text of one number; return 0 when the settings swallow it.
  function automatic bit predict_text(input logic [VALUE_W-1:0] raw);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] digits[$];
    text_byte_t         b;
    if (!settings_ok()) return 1'b0;
    base = VALUE_W'(cur_radix);
    neg  = raw[VALUE_W-1];
    // Unsigned negate: the most negative value gives 2^31 with no overflow.
    mag  = neg ? -raw : raw;
    do begin
      digits.push_front(DIGIT_W'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (neg) begin
      b.ch   = SYM_MINUS;
      b.last = 1'b0;
      pending_text.push_back(b);
    end
    foreach (digits[k]) begin
      b.ch   = symbol_for(digits[k]);
      b.last = (k == digits.size() - 1);
      pending_text.push_back(b);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check every byte at the rising edge, stall from the falling edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    text_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_seen++;
      if (pending_text.size() == 0) begin
        error_count++;
        $display("%0t: unexpected byte, expected none, actual char %h last %b",
                 $time, out_char, out_last);
      end else begin
        want = pending_text.pop_front();
        if (out_char !== want.ch) begin
          error_count++;
          $display("%0t: out_char mismatch, expected %h, actual %h",
                   $time, want.ch, out_char);
        end
        if (out_last !== want.last) begin
          error_count++;
          $display("%0t: out_last mismatch, expected %b, actual %b",
                   $time, want.last, out_last);
        end
      end
    end
  end

  // Draw a fresh stall after every byte transfer; hold ready low while it runs.
  always @(negedge clk) begin
    if (bytes_counted != bytes_seen) begin
      bytes_counted = bytes_seen;
      sink_hold     = $urandom_range(0, stall_max);
    end
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task starts and ends at a falling edge; a valid that
  // stays high on return is lowered or reused by the next caller in that step.
  // ---------------------------------------------------------------------------

  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    numbers_sent++;
    if (predict_text(v)) valid_numbers++;
    @(negedge clk);
  endtask

  // Drop the input, wait for every owed byte, and optionally let swallowed
  // numbers flush out of the pipe before touching the registers.
  task automatic wait_quiet(input bit settle);
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RADIX:        cur_radix = data[RADIX_W-1:0];
      CFG_SYMBOLS_LOW:  cur_table[CFG_DATA_W-1:0] = data;
      CFG_SYMBOLS_HIGH: cur_table[2*CFG_DATA_W-1:CFG_DATA_W] = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] radix_data,
                             input logic [2*CFG_DATA_W-1:0] table_bits);
    wait_quiet(1'b1);
    write_reg(CFG_RADIX, radix_data);
    write_reg(CFG_SYMBOLS_LOW, table_bits[CFG_DATA_W-1:0]);
    write_reg(CFG_SYMBOLS_HIGH, table_bits[2*CFG_DATA_W-1:CFG_DATA_W]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random symbol table whose first r entries are legal and distinct;
  // the unused upper entries are left as raw noise.
  function automatic logic [2*CFG_DATA_W-1:0] random_table(input int r);
    logic [2*CFG_DATA_W-1:0] t;
    logic [CHAR_W-1:0]       s;
    bit                      clash;
    t = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < r; i++) begin
      do begin
        s     = CHAR_W'($urandom_range(0, 255));
        clash = (s == SYM_NUL) || (s == SYM_PLUS) || (s == SYM_MINUS);
        for (int j = 0; j < i; j++)
          if (t[8*j +: 8] == s) clash = 1'b1;
      end while (clash);
      t[8*i +: 8] = s;
    end
    return t;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3, 4: begin
        v = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) v = -v;
      end
      5: v = {1'b1, {(VALUE_W-1){1'b0}}};
      6: v = {1'b0, {(VALUE_W-1){1'b1}}};
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Decimal with the reset table: zero, unit values, both extremes.
  task automatic test_reset_defaults();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1234567890);
  endtask

  // Base 2: the most negative value must come out as '-' plus 32 digits.
  task automatic test_base2_extremes();
    load_config(64'd2, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
  endtask

  // Base 16 uses all sixteen table entries, upper register included.
  task automatic test_base16_symbols();
    load_config(64'd16, {"fedcba98", "76543210"});
    send_value(32'hDEAD_BEEF);
    send_value(32'd255);
    send_value(-32'sd16);
  endtask

  // Radix 3: entries above digit 2 hold NUL, '+', '-' and repeats, all ignored.
  task automatic test_unused_symbols();
    load_config(64'd3, {64'h2D2D_2B00_3130_3232, 64'h2B2B_002D_0032_3130});
    send_value(32'd100);
    send_value(-32'sd5);
  endtask

  // Radix below 2 or above MAX_RADIX swallows the number; upper data bits ignored.
  task automatic test_invalid_radix();
    load_config(64'd0, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
    send_value(32'd7);
    load_config(64'hFFFF_FFFF_FFFF_FFE1, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
    send_value(32'd7);
    load_config(64'd17, {"fedcba98", "76543210"});
    send_value(-32'sd7);
    load_config(64'd31, {"fedcba98", "76543210"});
    send_value(32'd7);
  endtask

  // Decimal with one used entry turned into NUL, '+', '-' or a repeat.
  task automatic test_bad_symbols();
    logic [2*CFG_DATA_W-1:0] t;
    t = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};
    t[8*9 +: 8] = SYM_NUL;
    load_config(64'd10, t);
    send_value(32'd42);
    t = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};
    t[8*0 +: 8] = SYM_PLUS;
    load_config(64'd10, t);
    send_value(32'd42);
    t = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};
    t[8*5 +: 8] = SYM_MINUS;
    load_config(64'd10, t);
    send_value(-32'sd42);
    t = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};
    t[8*7 +: 8] = "3";
    load_config(64'd10, t);
    send_value(32'd42);
  endtask

  // A write to the spare index leaves the current (bad) settings alone; then
  // restore decimal, write the spare index again, and show one number still converts.
  task automatic test_unknown_index();
    wait_quiet(1'b1);
    write_reg(CFG_NONE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    load_config(64'd10, {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST});
    wait_quiet(1'b1);
    write_reg(CFG_NONE, 64'd2);
    cfg_valid <= 1'b0;
    send_value(-32'sd9876);
  endtask

  // Phases of random settings; mostly valid, some with a planted flaw.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0]   radix_data;
    logic [2*CFG_DATA_W-1:0] t;
    int                      r;
    int                      d0;
    int                      d1;
    int                      count;
    while (numbers_sent < RANDOM_ITEMS) begin
      // Some phases run with no gaps or stalls at all on one or both sides.
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      r          = $urandom_range(2, MAX_RADIX);
      t          = random_table(r);
      radix_data = {$urandom, $urandom};
      radix_data[RADIX_W-1:0] = RADIX_W'(r);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            d0 = $urandom_range(0, 16);
            radix_data[RADIX_W-1:0] = RADIX_W'((d0 < 2) ? d0 : d0 + 15);
          end
          1: begin
            d0 = $urandom_range(0, r - 1);
            case ($urandom_range(0, 2))
              0:       t[8*d0 +: 8] = SYM_NUL;
              1:       t[8*d0 +: 8] = SYM_PLUS;
              default: t[8*d0 +: 8] = SYM_MINUS;
            endcase
          end
          default: begin
            d1 = $urandom_range(1, r - 1);
            d0 = $urandom_range(0, d1 - 1);
            t[8*d1 +: 8] = t[8*d0 +: 8];
          end
        endcase
      end
      load_config(radix_data, t);
      count = settings_ok() ? $urandom_range(10, 30) : $urandom_range(2, 4);
      repeat (count) begin
        send_value(random_value());
        // Now and then hold the input until the block has caught up.
        if ($urandom_range(0, 40) == 0) wait_quiet(1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_base2_extremes();
    test_base16_symbols();
    test_unused_symbols();
    test_invalid_radix();
    test_bad_symbols();
    test_unknown_index();
    test_random_traffic();

    wait_quiet(1'b1);
    $display("covered: %0d numbers sent, %0d of them converted, %0d bytes checked",
             numbers_sent, valid_numbers, bytes_seen);
    $display("covered: %0d register settings, radix 0 to 31, bases 2 to 16, bad tables",
             settings_used);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d bytes outstanding", $time, pending_text.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/srta_pkg.sv
rtl/core/srta_cfg.sv
rtl/core/srta_front.sv
rtl/core/srta_queue.sv
rtl/core/srta_back.sv
rtl/core/signed_radix_to_ascii.sv
sim/tb_top.sv
